### sv/eils_pkg.sv
`timescale 1ns / 1ps
// eils_pkg: shared types and constants of the elf image layout scan
// depends on nothing; imported by every module of the block

package eils_pkg;

    localparam int ADDR_W      = 64;
    localparam int TYPE_W      = 32;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGES_W     = ADDR_W - PAGE_SHIFT;

    localparam logic [ADDR_W-1:0] PAGE_MASK = 64'h0000_0000_0000_0FFF;
    localparam logic [TYPE_W-1:0] LOAD_TYPE = 32'd1;

    localparam logic [ADDR_W-1:0] USER_HALF_LIMIT_RESET = 64'h0000_8000_0000_0000;
    localparam logic [ADDR_W-1:0] ENTRY_POINT_RESET     = 64'h0;

    // configuration register indexes
    localparam logic REG_USER_HALF_LIMIT = 1'b0;
    localparam logic REG_ENTRY_POINT     = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SEG    = 2'd1,
        ST_RANGE     = 2'd2,
        ST_ENTRY_OUT = 2'd3
    } status_t;

    // one header reduced to its page extent
    typedef struct packed {
        logic              ok;
        logic              err;
        logic              last;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] end_addr;
    } seg_t;

    // running state frozen at the last header
    typedef struct packed {
        logic              found;
        logic              err;
        logic [ADDR_W-1:0] low;
        logic [ADDR_W-1:0] high;
    } fin_t;

endpackage

### sv/elf_image_layout_scan.sv
`timescale 1ns / 1ps
// elf_image_layout_scan: top level, input register, stage handshakes, config registers
// depends on eils_pkg, eils_seg, eils_acc, eils_resolve
//
// Usage: program headers of one ELF64 image stream in on the s_ channel, one per
// request, the final header of the image marked by s_tlast. Each in-range LOAD header
// with a nonzero size widens the page-aligned image extent. Only a header with s_tlast
// produces a result on the m_ channel: status in m_tuser, base, size in bytes and
// pages, and the resolved entry in m_tdata; the running extent then starts over.
// Configuration (user half limit, entry point) is written through cfg_we, cfg_index
// and cfg_wdata; the user must do so only while no image is in flight (not enforced).
// A last header passes from the input register through the extent stage, the
// accumulator stage and the result register before it shows on m_tvalid.
// Throughput: one header per cycle while s_tready is high, set by the accumulator update.
// Each stage moves on when the stage after it is free, so headers keep flowing
// while a result waits; when m_tready stays low, s_tready drops only once the result
// register and the accumulator stage each hold a finished image, a third last header
// waits in the extent stage and the input register is full.
// Reset (aresetn low, synchronous) empties all stages, clears the running extent
// and loads the configuration reset values.

module elf_image_layout_scan
    import eils_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // segment_type [31:0], segment_vaddr [95:32], segment_memsize [159:96]
    input  logic [159:0]  s_tdata,
    input  logic          s_tlast,
    output logic          m_tvalid,
    input  logic          m_tready,
    // image_base [63:0], image_bytes [127:64], image_pages [179:128],
    // entry_address [243:180], zero fill [247:244]
    output logic [247:0]  m_tdata,
    // status [1:0]
    output logic [1:0]    m_tuser,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [63:0]   cfg_wdata
);

    logic [ADDR_W-1:0]  limit_reg;
    logic [ADDR_W-1:0]  entry_reg;
    logic               in_valid_reg;
    logic [TYPE_W-1:0]  type_reg;
    logic [ADDR_W-1:0]  vaddr_reg;
    logic [ADDR_W-1:0]  memsize_reg;
    logic               last_reg;

    logic               seg_valid;
    seg_t               seg;
    logic               fin_valid;
    fin_t               fin;
    logic               res_valid;
    status_t            status;
    logic [ADDR_W-1:0]  image_base;
    logic [ADDR_W-1:0]  image_bytes;
    logic [PAGES_W-1:0] image_pages;
    logic [ADDR_W-1:0]  entry_address;

    logic               rdy_res;
    logic               rdy_fin;
    logic               rdy_seg;
    logic               rdy_in;
    logic               seg_fire;

    // a non-last header leaves the extent stage without needing the next stage
    assign rdy_res  = !res_valid || m_tready;
    assign rdy_fin  = !fin_valid || rdy_res;
    assign rdy_seg  = !seg_valid || !seg.last || rdy_fin;
    assign rdy_in   = !in_valid_reg || rdy_seg;
    assign seg_fire = seg_valid && rdy_seg;
    assign s_tready = rdy_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= USER_HALF_LIMIT_RESET;
            entry_reg    <= ENTRY_POINT_RESET;
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_USER_HALF_LIMIT: limit_reg <= cfg_wdata;
                    REG_ENTRY_POINT:     entry_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (rdy_in) begin
                in_valid_reg <= s_tvalid;
            end
        end
        if (rdy_in) begin
            type_reg    <= s_tdata[31:0];
            vaddr_reg   <= s_tdata[95:32];
            memsize_reg <= s_tdata[159:96];
            last_reg    <= s_tlast;
        end
    end

    eils_seg u_seg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (rdy_seg),
        .in_valid        (in_valid_reg),
        .seg_type        (type_reg),
        .seg_vaddr       (vaddr_reg),
        .seg_memsize     (memsize_reg),
        .seg_last        (last_reg),
        .user_half_limit (limit_reg),
        .seg_valid       (seg_valid),
        .seg             (seg)
    );

    eils_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seg_fire  (seg_fire),
        .seg       (seg),
        .fin_load  (rdy_fin),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    eils_resolve u_resolve (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (rdy_res),
        .fin_valid     (fin_valid),
        .fin           (fin),
        .entry_point   (entry_reg),
        .res_valid     (res_valid),
        .status        (status),
        .image_base    (image_base),
        .image_bytes   (image_bytes),
        .image_pages   (image_pages),
        .entry_address (entry_address)
    );

    assign m_tvalid = res_valid;
    assign m_tuser  = status;
    assign m_tdata  = {4'b0000, entry_address, image_pages, image_bytes, image_base};

    // a resolved entry always lies inside the reported image
    a_entry_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status == ST_OK) |->
            (entry_address >= image_base) && (entry_address - image_base < image_bytes))
        else $error("resolved entry outside image");

    // failed scans report an empty image and no entry
    a_fail_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status == ST_RANGE || status == ST_NO_SEG)) |->
            (image_base == '0 && image_bytes == '0 && entry_address == '0))
        else $error("failed scan reports nonzero extent");

    // size is whole pages and the page count agrees with it
    a_page_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (image_bytes[PAGE_SHIFT-1:0] == '0)
            && ({image_pages, {PAGE_SHIFT{1'b0}}} == image_bytes))
        else $error("image size not in whole pages");

    // the input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && fin_valid))
        else $error("input stalled without a held result");

endmodule

### sv/eils_seg.sv
`timescale 1ns / 1ps
// eils_seg: page extent of one program header, registered
// depends on eils_pkg

module eils_seg
    import eils_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic              in_valid,
    input  logic [TYPE_W-1:0] seg_type,
    input  logic [ADDR_W-1:0] seg_vaddr,
    input  logic [ADDR_W-1:0] seg_memsize,
    input  logic              seg_last,
    input  logic [ADDR_W-1:0] user_half_limit,
    output logic              seg_valid,
    output seg_t              seg
);

    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] bytes;
    logic [ADDR_W-1:0] end_addr;
    logic              take;
    logic              bad;
    seg_t              seg_next;
    seg_t              seg_reg;
    logic              seg_valid_reg;

    always_comb begin
        base     = seg_vaddr & ~PAGE_MASK;
        bytes    = (seg_memsize + (seg_vaddr & PAGE_MASK) + PAGE_MASK) & ~PAGE_MASK;
        end_addr = base + bytes;
        // rounded size that wraps to zero is dropped without error
        take     = (seg_type == LOAD_TYPE) && (seg_memsize != '0) && (bytes != '0);
        bad      = (end_addr <= base) || (end_addr > user_half_limit);
        seg_next.ok       = take && !bad;
        seg_next.err      = take && bad;
        seg_next.last     = seg_last;
        seg_next.base     = base;
        seg_next.end_addr = end_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_valid_reg <= 1'b0;
        end else if (load) begin
            seg_valid_reg <= in_valid;
        end
        if (load) begin
            seg_reg <= seg_next;
        end
    end

    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

endmodule

### sv/eils_acc.sv
`timescale 1ns / 1ps
// eils_acc: running lowest base, highest end and sticky range error
// depends on eils_pkg; freezes the state into a register on the last header

module eils_acc
    import eils_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic seg_fire,
    input  seg_t seg,
    input  logic fin_load,
    output logic fin_valid,
    output fin_t fin
);

    logic              found_reg;
    logic              err_reg;
    logic [ADDR_W-1:0] low_reg;
    logic [ADDR_W-1:0] high_reg;
    fin_t              upd;
    fin_t              fin_reg;
    logic              fin_valid_reg;
    logic              fin_valid_next;

    always_comb begin
        upd.found = found_reg || seg.ok;
        upd.err   = err_reg || seg.err;
        upd.low   = low_reg;
        upd.high  = high_reg;
        if (seg.ok && (!found_reg || seg.base < low_reg)) begin
            upd.low = seg.base;
        end
        if (seg.ok && (!found_reg || seg.end_addr > high_reg)) begin
            upd.high = seg.end_addr;
        end
        fin_valid_next = seg_fire && seg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg     <= 1'b0;
            err_reg       <= 1'b0;
            fin_valid_reg <= 1'b0;
        end else begin
            if (seg_fire) begin
                // the last header closes the image and starts a fresh scan
                found_reg <= seg.last ? 1'b0 : upd.found;
                err_reg   <= seg.last ? 1'b0 : upd.err;
            end
            if (fin_load) begin
                fin_valid_reg <= fin_valid_next;
            end
        end
        if (seg_fire) begin
            low_reg  <= upd.low;
            high_reg <= upd.high;
        end
        if (fin_load) begin
            fin_reg <= upd;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule

### sv/eils_resolve.sv
`timescale 1ns / 1ps
// eils_resolve: image status, size and entry resolution into the result register
// depends on eils_pkg

module eils_resolve
    import eils_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic               fin_valid,
    input  fin_t               fin,
    input  logic [ADDR_W-1:0]  entry_point,
    output logic               res_valid,
    output status_t            status,
    output logic [ADDR_W-1:0]  image_base,
    output logic [ADDR_W-1:0]  image_bytes,
    output logic [PAGES_W-1:0] image_pages,
    output logic [ADDR_W-1:0]  entry_address
);

    logic [ADDR_W-1:0]  span;
    logic               in_image;
    logic               as_offset;
    status_t            status_next;
    logic [ADDR_W-1:0]  base_next;
    logic [ADDR_W-1:0]  bytes_next;
    logic [ADDR_W-1:0]  entry_next;
    logic               res_valid_reg;
    status_t            status_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [ADDR_W-1:0]  bytes_reg;
    logic [ADDR_W-1:0]  entry_reg;

    always_comb begin
        span      = fin.high - fin.low;
        in_image  = (entry_point >= fin.low) && (entry_point < fin.high);
        // an offset below the span cannot wrap past the image end
        as_offset = entry_point < span;
        status_next = ST_ENTRY_OUT;
        base_next   = '0;
        bytes_next  = '0;
        entry_next  = '0;
        priority if (fin.err) begin
            status_next = ST_RANGE;
        end else if (!fin.found || fin.high <= fin.low) begin
            status_next = ST_NO_SEG;
        end else begin
            base_next  = fin.low;
            bytes_next = span;
            if (fin.low != '0 && (in_image || as_offset)) begin
                status_next = ST_OK;
                entry_next  = in_image ? entry_point : entry_point + fin.low;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (load) begin
            res_valid_reg <= fin_valid;
        end
        if (load) begin
            status_reg <= status_next;
            base_reg   <= base_next;
            bytes_reg  <= bytes_next;
            entry_reg  <= entry_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign status        = status_reg;
    assign image_base    = base_reg;
    assign image_bytes   = bytes_reg;
    assign image_pages   = bytes_reg[ADDR_W-1:PAGE_SHIFT];
    assign entry_address = entry_reg;

endmodule

### tb/elf_image_layout_scan_tb.sv
`timescale 1ns / 1ps
// elf_image_layout_scan_tb: self-checking bench for the elf image layout scan
// streams program headers, predicts each image's extent and entry, checks m_ results
// depends on eils_pkg and elf_image_layout_scan

module elf_image_layout_scan_tb;
    import eils_pkg::*;

    typedef struct packed {
        logic [31:0] htype;
        logic [63:0] vaddr;
        logic [63:0] memsize;
        logic        last;
    } prog_hdr_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] base;
        logic [63:0] nbytes;
        logic [51:0] pages;
        logic [63:0] entry;
    } image_layout_t;

    localparam int HOLD_CYCLES = 300;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    // segment_type [31:0], segment_vaddr [95:32], segment_memsize [159:96]
    logic [159:0] s_tdata   = '0;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // image_base [63:0], image_bytes [127:64], image_pages [179:128],
    // entry_address [243:180], zero fill [247:244]
    logic [247:0] m_tdata;
    // status [1:0]
    logic [1:0]   m_tuser;
    logic         cfg_we    = 1'b0;
    logic         cfg_index = 1'b0;
    logic [63:0]  cfg_wdata = '0;

    elf_image_layout_scan u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // local copy of configuration and running extent
    logic [63:0] limit_model = USER_HALF_LIMIT_RESET;
    logic [63:0] entry_model = ENTRY_POINT_RESET;
    logic        ext_found   = 1'b0;
    logic        ext_err     = 1'b0;
    logic [63:0] ext_low     = '0;
    logic [63:0] ext_high    = '0;

    prog_hdr_t     pending_hdrs[$];
    image_layout_t expected_layouts[$];
    prog_hdr_t     offer;
    int            mismatches = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_seq = 0;
    int            hold_seen = 0;
    int            hold_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    // fold one accepted header into the extent; a last header yields the image layout
    function automatic void fold_header(input prog_hdr_t h);
        logic [63:0]   pbase;
        logic [63:0]   span;
        logic [63:0]   pend;
        logic [63:0]   cand;
        image_layout_t r;
        if (h.htype == LOAD_TYPE && h.memsize != 0) begin
            pbase = h.vaddr & ~PAGE_MASK;
            span  = (h.memsize + (h.vaddr - pbase) + PAGE_MASK) & ~PAGE_MASK;
            pend  = pbase + span;
            // a span that rounds to zero is skipped silently
            if (span != 0) begin
                if (pend <= pbase || pend > limit_model) begin
                    ext_err = 1'b1;
                end else begin
                    if (!ext_found || pbase < ext_low) ext_low = pbase;
                    if (!ext_found || pend > ext_high) ext_high = pend;
                    ext_found = 1'b1;
                end
            end
        end
        if (!h.last) return;
        r = '0;
        if (ext_err) begin
            r.status = ST_RANGE;
        end else if (!ext_found || ext_high <= ext_low) begin
            r.status = ST_NO_SEG;
        end else begin
            r.base   = ext_low;
            r.nbytes = ext_high - ext_low;
            r.pages  = r.nbytes[63:12];
            r.status = ST_ENTRY_OUT;
            if (ext_low != 0) begin
                if (entry_model >= ext_low && entry_model < ext_high) begin
                    r.entry  = entry_model;
                    r.status = ST_OK;
                end else if (entry_model < r.nbytes) begin
                    // entry taken as an offset from the image base
                    cand = entry_model + ext_low;
                    if (cand >= ext_low && cand < ext_high) begin
                        r.entry  = cand;
                        r.status = ST_OK;
                    end
                end
            end
        end
        expected_layouts.push_back(r);
        ext_found = 1'b0;
        ext_err   = 1'b0;
        ext_low   = '0;
        ext_high  = '0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) fold_header(offer);
            if (!s_tvalid || s_tready) begin
                if (pending_hdrs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    offer = pending_hdrs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {offer.memsize, offer.vaddr, offer.htype};
                    s_tlast  <= offer.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        image_layout_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_layouts.size() == 0) begin
                    $error("unexpected result: status %0d base %h", m_tuser, m_tdata[63:0]);
                    mismatches++;
                end else begin
                    want = expected_layouts.pop_front();
                    if (m_tuser != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        mismatches++;
                    end
                    if (m_tdata[63:0] != want.base) begin
                        $error("image_base: expected %h, got %h", want.base, m_tdata[63:0]);
                        mismatches++;
                    end
                    if (m_tdata[127:64] != want.nbytes) begin
                        $error("image_bytes: expected %h, got %h", want.nbytes,
                               m_tdata[127:64]);
                        mismatches++;
                    end
                    if (m_tdata[179:128] != want.pages) begin
                        $error("image_pages: expected %h, got %h", want.pages,
                               m_tdata[179:128]);
                        mismatches++;
                    end
                    if (m_tdata[243:180] != want.entry) begin
                        $error("entry_address: expected %h, got %h", want.entry,
                               m_tdata[243:180]);
                        mismatches++;
                    end
                end
            end
            // long hold-off so the pipeline backs up into s_tready
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    function automatic void push_hdr(input logic [31:0] ht, input logic [63:0] va,
                                     input logic [63:0] ms, input logic lst);
        prog_hdr_t h;
        h.htype   = ht;
        h.vaddr   = va;
        h.memsize = ms;
        h.last    = lst;
        pending_hdrs.push_back(h);
    endfunction

    task automatic write_reg(input logic idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_USER_HALF_LIMIT) limit_model = val;
        else entry_model = val;
    endtask

    // wait for every request and result, then let the pipeline empty out
    task automatic drain_scan();
        while (pending_hdrs.size() != 0 || s_tvalid || expected_layouts.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // random headers for one image, last not always marked; returns the header count
    function automatic int queue_image(input int max_hdrs);
        int          n;
        int unsigned pick;
        logic [31:0] ht;
        logic [63:0] va;
        logic [63:0] ms;
        logic        lst;
        n = $urandom_range(max_hdrs, 1);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99, 0);
            if (pick < 70) ht = LOAD_TYPE;
            else if (pick < 78) ht = 32'd0;
            else if (pick < 86) ht = 32'd2;
            else if (pick < 92) ht = 32'h6474_e551;
            else ht = $urandom;
            pick = $urandom_range(99, 0);
            if (pick < 55) begin
                va = 64'h40_0000 + 64'($urandom_range(32'hF_FFFF, 0));
                ms = 64'($urandom_range(32'h4_0000, 0));
            end else if (pick < 65) begin
                va = 64'($urandom_range(32'h3FFF, 0));
                ms = 64'($urandom_range(32'h8000, 0));
            end else if (pick < 75) begin
                va = limit_model - 64'($urandom_range(32'h4000, 0));
                ms = 64'($urandom_range(32'h4000, 0));
            end else if (pick < 85) begin
                va = {$urandom, $urandom};
                ms = $urandom_range(1, 0) ? {$urandom, $urandom} : 64'($urandom_range(65535, 0));
            end else if (pick < 92) begin
                // rounded size wraps to zero
                va = {$urandom, $urandom};
                ms = 64'd0 - {52'd0, va[11:0]} - 64'($urandom_range(32'hFFF, 1));
            end else begin
                // end wraps past the top of the address space
                va = 64'hFFFF_FFFF_FFFF_F000 | 64'($urandom_range(32'hFFF, 0));
                ms = 64'($urandom_range(32'h3000, 32'h1));
            end
            if ($urandom_range(19, 0) == 0) ms = '0;
            lst = (i == n - 1) && ($urandom_range(9, 0) != 0);
            push_hdr(ht, va, ms, lst);
        end
        return n;
    endfunction

    task automatic run_phase(input logic [63:0] lim, input logic [63:0] ent,
                             input int sidle, input int rstall, input int n_items,
                             input int max_hdrs, input bit pressure);
        int count;
        count = 0;
        drain_scan();
        write_reg(REG_USER_HALF_LIMIT, lim);
        write_reg(REG_ENTRY_POINT, ent);
        send_idle_pct  <= sidle;
        recv_stall_pct <= rstall;
        while (count < n_items) count += queue_image(max_hdrs);
        if (pressure) hold_seq <= hold_seq + 1;
        drain_scan();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed headers under reset configuration
        push_hdr(32'd2, 64'h40_0000, 64'h100, 1'b1);
        push_hdr(LOAD_TYPE, 64'h40_0000, 64'h0, 1'b1);
        push_hdr(LOAD_TYPE, 64'h40_0123, 64'h10, 1'b1);
        push_hdr(LOAD_TYPE, 64'h0, 64'h1000, 1'b1);
        push_hdr(LOAD_TYPE, 64'h1000, 64'hFFFF_FFFF_FFFF_F001, 1'b0);
        push_hdr(LOAD_TYPE, 64'h50_0000, 64'h2000, 1'b1);
        push_hdr(LOAD_TYPE, 64'h7FFF_FFFF_F000, 64'h2000, 1'b1);
        push_hdr(LOAD_TYPE, 64'h7FFF_FFFF_F000, 64'h2000, 1'b0);
        push_hdr(32'd3, 64'h0, 64'h0, 1'b1);
        push_hdr(LOAD_TYPE, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 1'b1);
        push_hdr(LOAD_TYPE, 64'h7FFF_FFFF_F000, 64'h1000, 1'b1);
        push_hdr(LOAD_TYPE, 64'h60_0000, 64'h1000, 1'b0);
        push_hdr(32'd6, 64'h10_0000, 64'h1000, 1'b0);
        push_hdr(LOAD_TYPE, 64'h40_0800, 64'h900, 1'b0);
        push_hdr(LOAD_TYPE, 64'h58_0000, 64'h1_0000, 1'b1);
        push_hdr(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        push_hdr(32'd0, 64'h0, 64'h0, 1'b1);
        drain_scan();
        // entry inside the image, as an offset, and outside
        write_reg(REG_ENTRY_POINT, 64'h40_1000);
        push_hdr(LOAD_TYPE, 64'h40_0000, 64'h2000, 1'b1);
        drain_scan();
        write_reg(REG_ENTRY_POINT, 64'h1800);
        push_hdr(LOAD_TYPE, 64'h40_0000, 64'h2000, 1'b1);
        drain_scan();
        write_reg(REG_ENTRY_POINT, 64'h2000);
        push_hdr(LOAD_TYPE, 64'h40_0000, 64'h2000, 1'b1);

        run_phase(USER_HALF_LIMIT_RESET, 64'h1000, 0, 0, 92, 5, 1'b0);
        run_phase(USER_HALF_LIMIT_RESET, 64'h40_0800, 77, 0, 92, 5, 1'b0);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 77, 92, 5, 1'b0);
        run_phase(64'h0, 64'h0, 27, 27, 92, 4, 1'b0);
        run_phase({24'h0, 8'($urandom_range(255, 1)), 32'h0},
                  64'($urandom_range(32'h8000, 0)), 0, 0, 92, 1, 1'b1);
        run_phase(64'h50_0000, 64'h40_0000, 77, 0, 92, 5, 1'b0);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 0, 77, 92, 6, 1'b0);
        run_phase(USER_HALF_LIMIT_RESET, {$urandom, $urandom} >> $urandom_range(63, 0),
                  27, 27, 92, 5, 1'b0);

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### elf_image_layout_scan.f
sv/eils_pkg.sv
sv/eils_seg.sv
sv/eils_acc.sv
sv/eils_resolve.sv
sv/elf_image_layout_scan.sv
tb/elf_image_layout_scan_tb.sv
